/* sv/bds_pkg.sv */
// Shared types and constants of the 2x2 box downsampler with luma.
package bds_pkg;

   // Fixed field widths.
   localparam int unsigned PIX_W   = 8;
   localparam int unsigned SUM_W   = 9;
   localparam int unsigned QUAD_W  = 10;
   localparam int unsigned POS_W   = 11;
   localparam int unsigned ROW_W   = 12;
   localparam int unsigned CSR_W   = 13;
   localparam int unsigned PROD_W  = 24;
   localparam int unsigned REQ_DATA_W = 24;
   localparam int unsigned RSP_DATA_W = 56;

   // Register reset value and width clamp floor.
   localparam logic [CSR_W-1:0] WIDTH_RESET = 13'd640;
   localparam int unsigned      WIDTH_MIN   = 2;

   // Q16 luma weights; they add up to exactly 65536.
   localparam logic [15:0] W_RED   = 16'd19661;
   localparam logic [15:0] W_GREEN = 16'd38666;
   localparam logic [15:0] W_BLUE  = 16'd7209;

   // One RGB pixel.
   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } pixel_type;

   // Three sums of a horizontal pixel pair.
   typedef struct packed {
      logic [SUM_W-1:0] red;
      logic [SUM_W-1:0] green;
      logic [SUM_W-1:0] blue;
   } pair_sum_type;

   // Control and position carried by the first pipeline stage.
   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
   } stage_ctrl_type;

endpackage

/* sv/bds_line_mem.sv */
// Line store of pair sums from the upper row, with a registered read port.
module bds_line_mem #(
   parameter int unsigned DEPTH  = 2048,
   parameter int unsigned ADDR_W = 11
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [ADDR_W-1:0]           wr_addr,
   input  bds_pkg::pair_sum_type       wr_data,
   input  logic                        rd_en,
   input  logic [ADDR_W-1:0]           rd_addr,
   output bds_pkg::pair_sum_type       rd_data
);
   import bds_pkg::*;

   pair_sum_type mem [DEPTH];
   pair_sum_type rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* sv/bds_avg_stage.sv */
// Block averages, luma and the result register.
module bds_avg_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              advance,
   input  bds_pkg::stage_ctrl_type           s1_ctrl,
   input  bds_pkg::pair_sum_type             s1_sum,
   input  bds_pkg::pair_sum_type             upper_sum,
   output logic                              rsp_tvalid,
   output logic [bds_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import bds_pkg::*;

   logic [QUAD_W-1:0] quad_red, quad_green, quad_blue;
   logic [PIX_W-1:0]  avg_red, avg_green, avg_blue;
   logic [PROD_W-1:0] prod_red, prod_green, prod_blue, luma_acc;
   logic [PIX_W-1:0]  luma;

   logic                  valid_ff;
   logic [RSP_DATA_W-1:0] data_ff;

   // Sum of the four pixels, divided by four.
   assign quad_red   = QUAD_W'(s1_sum.red)   + QUAD_W'(upper_sum.red);
   assign quad_green = QUAD_W'(s1_sum.green) + QUAD_W'(upper_sum.green);
   assign quad_blue  = QUAD_W'(s1_sum.blue)  + QUAD_W'(upper_sum.blue);
   assign avg_red    = quad_red[QUAD_W-1:2];
   assign avg_green  = quad_green[QUAD_W-1:2];
   assign avg_blue   = quad_blue[QUAD_W-1:2];

   // Weighted gray value with constant Q16 weights, truncated.
   assign prod_red   = PROD_W'(avg_red)   * PROD_W'(W_RED);
   assign prod_green = PROD_W'(avg_green) * PROD_W'(W_GREEN);
   assign prod_blue  = PROD_W'(avg_blue)  * PROD_W'(W_BLUE);
   assign luma_acc   = prod_red + prod_green + prod_blue;
   assign luma       = luma_acc[PROD_W-1:16];

   // Result register: valid is reset, payload is not.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= s1_ctrl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         data_ff <= {2'b00, s1_ctrl.row, s1_ctrl.column, luma,
                     avg_blue, avg_green, avg_red};
      end
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;

endmodule

/* sv/box_downsample_2x2_with_luma_core.sv */
// Top level of the 2x2 box downsampler with luma output.
// Each block passes the first stage and the line store read, then the result register.
// One input beat per cycle unless stalled; at most one line store access per beat.
// A result is given on the odd-column beat of an odd row; other beats give none.
// Reset (synchronous, active high) clears the counters, held pixel and valid flags,
// and sets the width to 640; the line store is not cleared and needs no clearing pass.
module box_downsample_2x2_with_luma_core #(
   parameter int unsigned MAX_WIDTH = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   // Configuration: image width in pixels.
   input  logic                              csr_wr_en,
   input  logic [bds_pkg::CSR_W-1:0]         csr_wr_data,
   // Input pixels.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // tdata fields from bit 0: red[7:0], green[15:8], blue[23:16].
   input  logic [bds_pkg::REQ_DATA_W-1:0]    req_tdata,
   // tuser fields from bit 0: frame_start[0].
   input  logic                              req_tuser,
   // Results.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // tdata fields from bit 0: red_avg[7:0], green_avg[15:8], blue_avg[23:16],
   // luma[31:24], out_column[42:32], out_row[53:43], zero fill[55:54].
   output logic [bds_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import bds_pkg::*;

   localparam int unsigned LINE_DEPTH = (MAX_WIDTH / 2 > 0) ? MAX_WIDTH / 2 : 1;
   localparam int unsigned IDX_W  = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
   localparam int unsigned CW_LOG = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int unsigned CW     = (CW_LOG > IDX_W + 1) ? CW_LOG : IDX_W + 1;
   localparam int unsigned CMP_W  = (CW + 1 > CSR_W + 1) ? CW + 1 : CSR_W + 1;

   logic [CW-1:0]    col_ff, col_in, col_cur;
   logic [ROW_W-1:0] row_ff, row_in, row_cur;
   pixel_type        held_ff, held_in;
   logic [CSR_W-1:0] width_ff;

   stage_ctrl_type   s1_ctrl_ff, s1_ctrl_in;
   pair_sum_type     s1_sum_ff;

   pixel_type        pix;
   pair_sum_type     pair_sum, upper_sum;
   logic             accept, advance, mem_wr, mem_rd, row_end;
   logic [CMP_W-1:0] width_eff, col_next;
   logic [31:0]      col_wide;
   logic [IDX_W-1:0] line_idx;

   // The pipeline moves whenever the result register is free or being taken.
   assign advance    = !rsp_tvalid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && req_tready;
   assign pix        = pixel_type'(req_tdata);

   // Position of the current beat; a frame start puts it at the origin.
   assign col_cur = req_tuser ? '0 : col_ff;
   assign row_cur = req_tuser ? '0 : row_ff;

   // Width clamped to the supported range.
   always_comb begin
      width_eff = CMP_W'(width_ff);
      if (width_eff < CMP_W'(WIDTH_MIN)) begin
         width_eff = CMP_W'(WIDTH_MIN);
      end
      if (width_eff > CMP_W'(MAX_WIDTH)) begin
         width_eff = CMP_W'(MAX_WIDTH);
      end
   end

   // Column and row advance; the row ends once the next column reaches the width.
   assign col_next = CMP_W'(col_cur) + CMP_W'(1);
   assign row_end  = col_next >= width_eff;

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      held_in = held_ff;
      if (accept) begin
         if (row_end) begin
            col_in = '0;
            row_in = row_cur + ROW_W'(1);
         end else begin
            col_in = CW'(col_next);
            row_in = row_cur;
         end
         if (!col_cur[0]) begin
            held_in = pix;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff   <= '0;
         row_ff   <= '0;
         held_ff  <= '0;
         width_ff <= WIDTH_RESET;
      end else begin
         col_ff  <= col_in;
         row_ff  <= row_in;
         held_ff <= held_in;
         if (csr_wr_en) begin
            width_ff <= csr_wr_data;
         end
      end
   end

   // Horizontal pair sums; an upper row stores them, a lower row reads them back.
   assign pair_sum.red   = SUM_W'(held_ff.red)   + SUM_W'(pix.red);
   assign pair_sum.green = SUM_W'(held_ff.green) + SUM_W'(pix.green);
   assign pair_sum.blue  = SUM_W'(held_ff.blue)  + SUM_W'(pix.blue);
   assign line_idx = col_cur[IDX_W:1];
   assign mem_wr   = accept && col_cur[0] && !row_cur[0];
   assign mem_rd   = accept && col_cur[0] && row_cur[0];

   bds_line_mem #(
      .DEPTH  (LINE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_line_mem (
      .clock   (clock),
      .wr_en   (mem_wr),
      .wr_addr (line_idx),
      .wr_data (pair_sum),
      .rd_en   (mem_rd),
      .rd_addr (line_idx),
      .rd_data (upper_sum)
   );

   // First stage: lower-row pair sums and the output position.
   assign col_wide          = 32'(col_cur);
   assign s1_ctrl_in.valid  = mem_rd;
   assign s1_ctrl_in.column = col_wide[POS_W:1];
   assign s1_ctrl_in.row    = row_cur[POS_W:1];

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctrl_ff.valid <= 1'b0;
      end else if (advance) begin
         s1_ctrl_ff.valid <= s1_ctrl_in.valid;
      end
      if (accept) begin
         s1_ctrl_ff.column <= s1_ctrl_in.column;
         s1_ctrl_ff.row    <= s1_ctrl_in.row;
         s1_sum_ff         <= pair_sum;
      end
   end

   bds_avg_stage u_avg_stage (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .s1_ctrl    (s1_ctrl_ff),
      .s1_sum     (s1_sum_ff),
      .upper_sum  (upper_sum),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* sv/bds_checker.sv */
// Port-level checks of the downsampler, bound to the top level.
module bds_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_tready,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [bds_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import bds_pkg::*;

   logic [PIX_W-1:0] chk_red, chk_green, chk_blue, chk_luma;

   assign chk_red   = rsp_tdata[7:0];
   assign chk_green = rsp_tdata[15:8];
   assign chk_blue  = rsp_tdata[23:16];
   assign chk_luma  = rsp_tdata[31:24];

   // A stalled result beat holds its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled result beat changed");

   // Reset leaves no result pending.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // Input is taken exactly when the result register can move.
   a_ready_link: assert property (@(posedge clock) disable iff (reset)
      req_tready == (!rsp_tvalid || rsp_tready))
      else $error("input ready does not follow result stall");

   // The luma lies between the smallest and largest channel average.
   a_luma_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (chk_luma <= chk_red || chk_luma <= chk_green || chk_luma <= chk_blue)
                  && (chk_luma >= chk_red || chk_luma >= chk_green || chk_luma >= chk_blue))
      else $error("luma outside the range of the averages");

endmodule

bind box_downsample_2x2_with_luma_core bds_checker u_bds_checker (.*);

/* sim/box_downsample_2x2_with_luma_checker.sv */
// Checker for the 2x2 box downsampler: predicts each block result and compares it.
module box_downsample_2x2_with_luma_checker
   import bds_pkg::*;
#(
   parameter int unsigned MAX_WIDTH = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_W-1:0]      csr_wr_data,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic                  req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   output int unsigned           mismatch_count,
   output int unsigned           pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned LINE_DEPTH = MAX_WIDTH / 2;

   // Result beat layout, lowest field last.
   typedef struct packed {
      logic [1:0]       fill;
      logic [POS_W-1:0] row;
      logic [POS_W-1:0] column;
      logic [PIX_W-1:0] luma;
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } block_result_type;

   // Own copy of the block state.
   pair_sum_type     pair_line [LINE_DEPTH];
   pixel_type        held_px;
   logic [ROW_W-1:0] col_pos;
   logic [ROW_W-1:0] row_pos;
   logic [CSR_W-1:0] width_reg;

   block_result_type expected_blocks [$];
   int unsigned      mismatches = 0;
   int unsigned      queued = 0;

   assign mismatch_count = mismatches;
   assign pending_count  = queued;

   // Widths below the floor act as the floor, widths above the line store as its size.
   function automatic int unsigned clamp_width(input logic [CSR_W-1:0] w);
      if (w < WIDTH_MIN) return WIDTH_MIN;
      if (w > MAX_WIDTH) return MAX_WIDTH;
      return w;
   endfunction

   // Advance the position by one pixel and queue the block average it completes.
   task automatic predict_pixel(input logic frame_start, input pixel_type px);
      pair_sum_type     pair;
      pair_sum_type     upper;
      block_result_type blk;
      int unsigned      idx;
      int unsigned      ar;
      int unsigned      ag;
      int unsigned      ab;
      int unsigned      y;
      int unsigned      w;
      w = clamp_width(width_reg);
      if (frame_start) begin
         col_pos = '0;
         row_pos = '0;
      end
      if (!col_pos[0]) begin
         held_px = px;
      end else begin
         idx = (col_pos >> 1) % LINE_DEPTH;
         pair.red   = {1'b0, held_px.red}   + {1'b0, px.red};
         pair.green = {1'b0, held_px.green} + {1'b0, px.green};
         pair.blue  = {1'b0, held_px.blue}  + {1'b0, px.blue};
         if (!row_pos[0]) begin
            pair_line[idx] = pair;
         end else begin
            upper = pair_line[idx];
            ar = (pair.red + upper.red) >> 2;
            ag = (pair.green + upper.green) >> 2;
            ab = (pair.blue + upper.blue) >> 2;
            y  = (W_RED * ar + W_GREEN * ag + W_BLUE * ab) >> 16;
            blk.fill   = '0;
            blk.red    = ar[PIX_W-1:0];
            blk.green  = ag[PIX_W-1:0];
            blk.blue   = ab[PIX_W-1:0];
            blk.luma   = y[PIX_W-1:0];
            blk.column = col_pos[POS_W:1];
            blk.row    = row_pos[POS_W:1];
            expected_blocks.push_back(blk);
         end
      end
      // The row ends once the next column would reach the width; rows wrap at 12 bits.
      if (col_pos + 1 >= w) begin
         col_pos = '0;
         row_pos = row_pos + 1'b1;
      end else begin
         col_pos = col_pos + 1'b1;
      end
   endtask

   // Compare one result beat with the oldest queued block, field by field.
   task automatic compare_block(input block_result_type got);
      block_result_type want;
      if (expected_blocks.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("unexpected result beat: rgb %0d %0d %0d luma %0d at %0d,%0d",
                     got.red, got.green, got.blue, got.luma, got.column, got.row);
      end else begin
         want = expected_blocks.pop_front();
         if (got.red !== want.red || got.green !== want.green || got.blue !== want.blue ||
             got.luma !== want.luma || got.column !== want.column ||
             got.row !== want.row || got.fill !== want.fill) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("result mismatch: expected rgb %0d %0d %0d luma %0d at %0d,%0d fill %0d",
                        want.red, want.green, want.blue, want.luma, want.column, want.row,
                        want.fill);
               $display("                 actual   rgb %0d %0d %0d luma %0d at %0d,%0d fill %0d",
                        got.red, got.green, got.blue, got.luma, got.column, got.row,
                        got.fill);
            end
         end
      end
   endtask

   // Results pass the first stage and the result register after their pixel, so the
   // result beat is checked before the pixel beat of the same edge is predicted.
   always @(posedge clock) begin
      if (reset) begin
         col_pos   = '0;
         row_pos   = '0;
         held_px   = '0;
         width_reg = WIDTH_RESET;
         expected_blocks.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) compare_block(rsp_tdata);
         if (req_tvalid && req_tready) predict_pixel(req_tuser, req_tdata);
         if (csr_wr_en) width_reg = csr_wr_data;
      end
      queued <= expected_blocks.size();
   end

endmodule

/* sim/tb_box_downsample_2x2_with_luma_core.sv */
// Testbench top for the 2x2 box downsampler: clock, reset, pixel stimulus and verdict.
module tb_box_downsample_2x2_with_luma_core;
   timeunit 1ns;
   timeprecision 1ps;
   import bds_pkg::*;

   localparam int unsigned MAX_WIDTH     = 4096;
   localparam int unsigned RANDOM_PIXELS = 1800;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  csr_wr_en = 1'b0;
   logic [CSR_W-1:0]      csr_wr_data = '0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;

   int unsigned mismatch_count;
   int unsigned pending_count;

   // Stimulus bookkeeping: idle-free stretches, effective width, forced frame start.
   bit          no_idle = 1'b0;
   int unsigned cur_width = WIDTH_RESET;
   bit          need_start = 1'b0;

   box_downsample_2x2_with_luma_core #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   box_downsample_2x2_with_luma_checker #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_checker (
      .clock         (clock),
      .reset         (reset),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .req_tuser     (req_tuser),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .mismatch_count(mismatch_count),
      .pending_count (pending_count)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned draw_gap();
      return no_idle ? 0 : $urandom_range(0, 5);
   endfunction

   function automatic pixel_type rgb(input logic [7:0] r, input logic [7:0] g,
                                     input logic [7:0] b);
      pixel_type px;
      px.red   = r;
      px.green = g;
      px.blue  = b;
      return px;
   endfunction

   // Random samples with extra weight on the extremes.
   function automatic logic [7:0] random_sample();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'd255 : 8'd0;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic pixel_type random_pixel();
      return rgb(random_sample(), random_sample(), random_sample());
   endfunction

   // Send one pixel beat after a random gap; called and returning at a falling edge.
   task automatic send_pixel(input logic frame_start, input pixel_type px);
      int unsigned gap;
      if ($urandom_range(0, 99) == 0) no_idle = !no_idle;
      gap = draw_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= frame_start | need_start;
      req_tdata  <= px;
      need_start = 1'b0;
      @(posedge clock);
      while (req_tready !== 1'b1) @(posedge clock);
      @(negedge clock);
   endtask

   // Drain all queued results, then let the pipeline settle.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // Write the width while idle; a wider row forces a frame start on the next beat.
   task automatic write_width(input logic [CSR_W-1:0] value);
      int unsigned eff;
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      eff = (value < WIDTH_MIN) ? WIDTH_MIN : (value > MAX_WIDTH) ? MAX_WIDTH : value;
      if (eff > cur_width) need_start = 1'b1;
      cur_width = eff;
   endtask

   // Result side: a random stall before each beat.
   initial begin
      int unsigned gap;
      @(negedge clock);
      forever begin
         gap = draw_gap();
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (rsp_tvalid !== 1'b1);
         @(negedge clock);
      end
   end

   // Safety net against a hung handshake.
   initial begin
      #1500000;
      $display("tb_box_downsample_2x2_with_luma_core NOT OK");
      $finish;
   end

   // Pixel stimulus and verdict.
   initial begin
      int unsigned random_sent;
      int unsigned wv;
      int unsigned height;
      bit          first;
      logic        fs;
      int          p;

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Width below the floor: full-scale, all-zero and one primary per pixel.
      write_width(13'd0);
      send_pixel(1'b1, rgb(8'd255, 8'd255, 8'd255));
      repeat (3) send_pixel(1'b0, rgb(8'd255, 8'd255, 8'd255));
      repeat (4) send_pixel(1'b0, rgb(8'd0, 8'd0, 8'd0));
      send_pixel(1'b0, rgb(8'd255, 8'd0, 8'd0));
      send_pixel(1'b0, rgb(8'd0, 8'd255, 8'd0));
      send_pixel(1'b0, rgb(8'd0, 8'd0, 8'd255));
      send_pixel(1'b0, rgb(8'd3, 8'd3, 8'd3));

      // Sums of three that truncate to zero.
      write_width(13'd1);
      send_pixel(1'b1, rgb(8'd3, 8'd0, 8'd1));
      send_pixel(1'b0, rgb(8'd0, 8'd2, 8'd1));
      send_pixel(1'b0, rgb(8'd0, 8'd1, 8'd0));
      send_pixel(1'b0, rgb(8'd0, 8'd0, 8'd1));

      // Odd width and odd height: the last column and the last row give nothing.
      write_width(13'd3);
      for (p = 0; p < 9; p++) send_pixel(p == 0, random_pixel());

      // Random frames: mostly well formed, with missing and stray frame starts
      // and width cuts in the middle of a row.
      random_sent = 0;
      while (random_sent < RANDOM_PIXELS) begin
         case ($urandom_range(0, 9))
            0:       wv = $urandom_range(0, 1);
            1:       wv = $urandom_range(25, 200);
            default: wv = $urandom_range(2, 24);
         endcase
         write_width(CSR_W'(wv));
         repeat ($urandom_range(1, 3)) begin
            height = (cur_width > 24) ? $urandom_range(1, 3) : $urandom_range(1, 8);
            first  = ($urandom_range(0, 9) != 0);
            for (p = 0; p < height * cur_width; p++) begin
               fs = (p == 0) ? first : ($urandom_range(0, 199) == 0);
               send_pixel(fs, random_pixel());
               random_sent++;
               if (cur_width > 2 && $urandom_range(0, 149) == 0)
                  write_width(CSR_W'($urandom_range(2, cur_width - 1)));
            end
         end
      end

      // Widest row with all width bits set, then narrowing in an even and an odd row.
      write_width(13'h1FFF);
      for (p = 0; p < 2 * MAX_WIDTH + 100; p++) send_pixel(p == 0, random_pixel());
      write_width(13'd40);
      for (p = 0; p < 1 + 40 * 2 + 17; p++) send_pixel(1'b0, random_pixel());
      write_width(13'd9);
      for (p = 0; p < 9 * 4; p++) send_pixel(1'b0, random_pixel());

      // Narrowest rows past the row counter wrap, without further frame starts.
      write_width(13'd2);
      for (p = 0; p < 2 * 4098; p++) send_pixel(p == 0, random_pixel());

      wait_idle();
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("tb_box_downsample_2x2_with_luma_core OK");
      end else begin
         $display("tb_box_downsample_2x2_with_luma_core NOT OK");
      end
      $finish;
   end

endmodule
